[rtl/core/pss_pkg.sv]
// shared sizes, status codes and beat payload types for the packed string store
package pss_pkg;

   localparam int STORE_BYTES = 256;
   localparam int MAX_STRING  = 80;

   localparam int ADDR_W  = $clog2(STORE_BYTES);
   localparam int LEN_W   = $clog2(STORE_BYTES + 1);
   localparam int SUM_W   = LEN_W + 1;
   localparam int STG_AW  = $clog2(MAX_STRING);
   localparam int SCNT_W  = $clog2(MAX_STRING + 1);

   localparam logic [2:0] STATUS_PENDING     = 3'd0;
   localparam logic [2:0] STATUS_STORED      = 3'd1;
   localparam logic [2:0] STATUS_STORED_FULL = 3'd2;
   localparam logic [2:0] STATUS_EVICTED     = 3'd3;
   localparam logic [2:0] STATUS_NO_ROOM     = 3'd4;
   localparam logic [2:0] STATUS_TOO_LONG    = 3'd5;
   localparam logic [2:0] STATUS_EMPTY       = 3'd6;
   localparam logic [2:0] STATUS_READ        = 3'd7;

   localparam logic REQ_CHAR = 1'b0;
   localparam logic REQ_READ = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic       has_char;
      logic [7:0] char_in;
      logic       last;
      logic       allow_evict;
      logic [7:0] read_addr;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] status;
      logic [8:0] evicted_bytes;
      logic [8:0] used_bytes;
      logic [7:0] read_data;
   } rsp_payload_type;

endpackage

[rtl/core/packed_string_store_with_eviction.sv]
// packed string store: staging buffer, byte store and commit sequencer
//
//   channel | dir | handshake              | payload
//   req     | in  | req_valid / req_ready  | req_data (req_payload_type)
//   rsp     | out | rsp_valid / rsp_ready  | rsp_data (rsp_payload_type)
//
// the byte store has one read and one write port
// commit without eviction: each staged byte is read, then written to the store
// commit with eviction: walks to the eviction point, shifts the survivors to the front,
// appends the new string, then zeroes the bytes up to the old used length
// reset starts a pass that zeroes the byte store; req_ready is low meanwhile
// a waiting response holds the sequencer in its finish state; req_ready is low until idle
module packed_string_store_with_eviction (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  pss_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output pss_pkg::rsp_payload_type rsp_data
);
   import pss_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECIDE,
      ST_WALK_RD,
      ST_WALK_CK,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_APP_RD,
      ST_APP_WR,
      ST_ZERO,
      ST_FINISH
   } state_type;

   state_type       state_ff, state_in;
   req_payload_type req_ff, req_in;
   logic [SCNT_W-1:0] cnt_ff, cnt_in;
   logic            over_ff, over_in;
   logic [LEN_W-1:0] used_ff, used_in;
   logic [LEN_W-1:0] ptr_ff, ptr_in;
   logic [LEN_W-1:0] dst_ff, dst_in;
   logic [SCNT_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] evict_ff, evict_in;
   logic [LEN_W-1:0] zend_ff, zend_in;
   logic [2:0]      status_ff, status_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic [7:0] store_mem [STORE_BYTES];
   logic [7:0] stage_mem [MAX_STRING];
   logic [7:0] store_q_ff;
   logic [7:0] stage_q_ff;

   logic              store_we, store_re, stage_we, stage_re;
   logic [ADDR_W-1:0] store_wa, store_ra;
   logic [7:0]        store_wd;
   logic [STG_AW-1:0] stage_ra;

   logic [SUM_W-1:0] need;
   logic [SUM_W-1:0] plain_sum;
   logic             read_in_range;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign need          = SUM_W'(cnt_ff) + SUM_W'(1);
   assign plain_sum     = SUM_W'(used_ff) + need;
   assign read_in_range = (32'(req_ff.read_addr) < 32'(STORE_BYTES));

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cnt_in       = cnt_ff;
      over_in      = over_ff;
      used_in      = used_ff;
      ptr_in       = ptr_ff;
      dst_in       = dst_ff;
      idx_in       = idx_ff;
      evict_in     = evict_ff;
      zend_in      = zend_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      store_we     = 1'b0;
      store_wa     = '0;
      store_wd     = '0;
      store_re     = 1'b0;
      store_ra     = '0;
      stage_we     = 1'b0;
      stage_re     = 1'b0;
      stage_ra     = '0;

      unique case (state_ff)
         // zero the byte store once after reset
         ST_CLEAR: begin
            store_we = 1'b1;
            store_wa = ptr_ff[ADDR_W-1:0];
            store_wd = 8'd0;
            ptr_in   = ptr_ff + LEN_W'(1);
            if (ptr_ff == LEN_W'(STORE_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               evict_in = '0;
               if (req_data.req_type == REQ_READ) begin
                  store_re  = 1'b1;
                  store_ra  = ADDR_W'(req_data.read_addr);
                  status_in = STATUS_READ;
                  state_in  = ST_FINISH;
               end else begin
                  if (req_data.has_char && (req_data.char_in != 8'd0)) begin
                     if (cnt_ff < SCNT_W'(MAX_STRING)) begin
                        stage_we = 1'b1;
                        cnt_in   = cnt_ff + SCNT_W'(1);
                     end else begin
                        over_in = 1'b1;
                     end
                  end
                  if (req_data.last) begin
                     state_in = ST_DECIDE;
                  end else begin
                     status_in = STATUS_PENDING;
                     state_in  = ST_FINISH;
                  end
               end
            end
         end
         ST_DECIDE: begin
            if (over_ff) begin
               status_in = STATUS_TOO_LONG;
               cnt_in    = '0;
               over_in   = 1'b0;
               state_in  = ST_FINISH;
            end else if (cnt_ff == '0) begin
               status_in = STATUS_EMPTY;
               state_in  = ST_FINISH;
            end else if (plain_sum <= SUM_W'(STORE_BYTES)) begin
               dst_in   = used_ff;
               idx_in   = '0;
               state_in = ST_APP_RD;
            end else if ((need > SUM_W'(STORE_BYTES)) || !req_ff.allow_evict) begin
               status_in = STATUS_NO_ROOM;
               cnt_in    = '0;
               over_in   = 1'b0;
               state_in  = ST_FINISH;
            end else begin
               ptr_in   = '0;
               state_in = ST_WALK_RD;
            end
         end
         // find the end of the oldest strings that free at least need bytes
         ST_WALK_RD: begin
            if (ptr_ff == used_ff) begin
               evict_in = used_ff;
               dst_in   = '0;
               state_in = ST_SHIFT_RD;
            end else begin
               store_re = 1'b1;
               store_ra = ptr_ff[ADDR_W-1:0];
               state_in = ST_WALK_CK;
            end
         end
         ST_WALK_CK: begin
            ptr_in = ptr_ff + LEN_W'(1);
            if ((store_q_ff == 8'd0) && ((SUM_W'(ptr_ff) + SUM_W'(1)) >= need)) begin
               evict_in = ptr_ff + LEN_W'(1);
               dst_in   = '0;
               state_in = ST_SHIFT_RD;
            end else begin
               state_in = ST_WALK_RD;
            end
         end
         // move the surviving strings to the front
         ST_SHIFT_RD: begin
            if (ptr_ff == used_ff) begin
               zend_in  = used_ff;
               idx_in   = '0;
               state_in = ST_APP_RD;
            end else begin
               store_re = 1'b1;
               store_ra = ptr_ff[ADDR_W-1:0];
               state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            store_we = 1'b1;
            store_wa = dst_ff[ADDR_W-1:0];
            store_wd = store_q_ff;
            ptr_in   = ptr_ff + LEN_W'(1);
            dst_in   = dst_ff + LEN_W'(1);
            state_in = ST_SHIFT_RD;
         end
         ST_APP_RD: begin
            if (idx_ff == cnt_ff) begin
               // terminator closes the new string
               store_we = 1'b1;
               store_wa = dst_ff[ADDR_W-1:0];
               store_wd = 8'd0;
               used_in  = dst_ff + LEN_W'(1);
               cnt_in   = '0;
               over_in  = 1'b0;
               if (evict_ff != '0) begin
                  ptr_in   = dst_ff + LEN_W'(1);
                  state_in = ST_ZERO;
               end else begin
                  status_in = ((SUM_W'(dst_ff) + SUM_W'(3)) > SUM_W'(STORE_BYTES)) ?
                              STATUS_STORED_FULL : STATUS_STORED;
                  state_in  = ST_FINISH;
               end
            end else begin
               stage_re = 1'b1;
               stage_ra = idx_ff[STG_AW-1:0];
               state_in = ST_APP_WR;
            end
         end
         ST_APP_WR: begin
            store_we = 1'b1;
            store_wa = dst_ff[ADDR_W-1:0];
            store_wd = stage_q_ff;
            dst_in   = dst_ff + LEN_W'(1);
            idx_in   = idx_ff + SCNT_W'(1);
            state_in = ST_APP_RD;
         end
         // clear what the old strings left behind the new used length
         ST_ZERO: begin
            if (ptr_ff >= zend_ff) begin
               status_in = STATUS_EVICTED;
               state_in  = ST_FINISH;
            end else begin
               store_we = 1'b1;
               store_wa = ptr_ff[ADDR_W-1:0];
               store_wd = 8'd0;
               ptr_in   = ptr_ff + LEN_W'(1);
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.status        = status_ff;
               rsp_in.evicted_bytes = 9'(evict_ff);
               rsp_in.used_bytes    = 9'(used_ff);
               rsp_in.read_data     = ((req_ff.req_type == REQ_READ) && read_in_range) ?
                                      store_q_ff : 8'd0;
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         over_ff      <= 1'b0;
         used_ff      <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         over_ff      <= over_in;
         used_ff      <= used_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff    <= req_in;
      dst_ff    <= dst_in;
      idx_ff    <= idx_in;
      evict_ff  <= evict_in;
      zend_ff   <= zend_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   // byte store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_wa] <= store_wd;
      end
      if (store_re) begin
         store_q_ff <= store_mem[store_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_we) begin
         stage_mem[cnt_ff[STG_AW-1:0]] <= req_data.char_in;
      end
      if (stage_re) begin
         stage_q_ff <= stage_mem[stage_ra];
      end
   end

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      32'(used_ff) <= STORE_BYTES)
      else $error("used length beyond store size");

   a_staged_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= MAX_STRING)
      else $error("staged count beyond max string");

   a_evict_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == STATUS_EVICTED)) |-> (rsp_ff.evicted_bytes != 9'd0))
      else $error("eviction beat with no evicted bytes");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_FINISH) |-> !store_we)
      else $error("store written outside commit");

   a_commit_clears: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == ST_DECIDE && state_ff == ST_FINISH) |-> (cnt_ff == '0 && !over_ff))
      else $error("staging not cleared after commit");

endmodule
